### src/cmst_pkg.sv
// Shared types, character codes and register indexes for the comment strip filter.
package cmst_pkg;

  // Character codes
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Configuration register word indexes (byte address 4*i)
  localparam int unsigned       REG_AW       = 4;
  localparam logic [1:0]        REG_LINE_EN  = 2'd0;
  localparam logic [1:0]        REG_KEEP     = 2'd1;
  localparam logic [1:0]        REG_WARN_EN  = 2'd2;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_BLOCK      = 3'd2,
    MODE_BLOCK_STAR = 3'd3,
    MODE_LINE       = 3'd4
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       nested_warning;
    logic       unterminated_error;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic line_comments_enable;
    logic keep_comment_text;
    logic warn_nested_enable;
  } cfg_t;

  typedef struct packed {
    scan_mode_e scan_mode;
    logic       in_double_quote;
    logic       in_single_quote;
    logic       escape_pending;
    logic       body_slash_seen;
    logic       warned_this_line;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    scan_mode:        MODE_NORMAL,
    in_double_quote:  1'b0,
    in_single_quote:  1'b0,
    escape_pending:   1'b0,
    body_slash_seen:  1'b0,
    warned_this_line: 1'b0
  };

  // Build one result; the character reads as zero when not valid.
  function automatic out_item_t mk_res(logic [7:0] ch, logic valid, logic warn, logic err);
    out_item_t r;
    r.out_char           = valid ? ch : 8'h00;
    r.char_valid         = valid;
    r.nested_warning     = warn;
    r.unterminated_error = err;
    r.last               = 1'b0;
    return r;
  endfunction

endpackage

### src/cmst_step.sv
// Next-state and result logic for one character of the comment strip filter.
module cmst_step (
  input  cmst_pkg::cfg_t        cfg_i,
  input  cmst_pkg::scan_state_t state_i,
  input  cmst_pkg::in_item_t    item_i,
  output cmst_pkg::scan_state_t state_o,
  output cmst_pkg::out_item_t   res0_o,
  output cmst_pkg::out_item_t   res1_o,
  output logic [1:0]            res_cnt_o
);
  import cmst_pkg::*;

  always_comb begin
    scan_state_t s;
    out_item_t   r0;
    out_item_t   r1;
    logic [1:0]  n;
    logic [7:0]  c;
    logic        keep;
    logic        warn;
    logic        do_normal;
    logic        do_body;
    logic        body_put;

    s         = state_i;
    r0        = '0;
    r1        = '0;
    n         = 2'd0;
    c         = item_i.in_byte;
    keep      = cfg_i.keep_comment_text;
    warn      = 1'b0;
    do_normal = 1'b0;
    do_body   = 1'b0;
    body_put  = 1'b1;

    // Decide the path for this transaction
    if (item_i.end_of_text) begin
      if (state_i.scan_mode == MODE_SLASH) begin
        r0 = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0);
        n  = 2'd1;
      end else if (state_i.scan_mode == MODE_BLOCK || state_i.scan_mode == MODE_BLOCK_STAR) begin
        if (keep) begin
          r0 = mk_res(CH_STAR, 1'b1, 1'b0, 1'b1);
          r1 = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0);
          n  = 2'd2;
        end else begin
          r0 = mk_res(8'h00, 1'b0, 1'b0, 1'b1);
          n  = 2'd1;
        end
      end else begin
        r0 = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
        n  = 2'd1;
      end
      s = SCAN_STATE_RESET;
    end else begin
      unique case (state_i.scan_mode)
        MODE_SLASH: begin
          if (c == CH_STAR || (c == CH_SLASH && cfg_i.line_comments_enable)) begin
            s.scan_mode       = (c == CH_STAR) ? MODE_BLOCK : MODE_LINE;
            s.body_slash_seen = 1'b0;
            if (keep) begin
              r0 = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0);
              r1 = mk_res(c, 1'b1, 1'b0, 1'b0);
              n  = 2'd2;
            end else begin
              r0 = mk_res(CH_SPACE, 1'b1, 1'b0, 1'b0);
              n  = 2'd1;
            end
          end else begin
            // Release the held slash, then treat the character as text
            s.scan_mode = MODE_NORMAL;
            r0          = mk_res(CH_SLASH, 1'b1, 1'b0, 1'b0);
            n           = 2'd1;
            do_normal   = 1'b1;
          end
        end
        MODE_BLOCK, MODE_BLOCK_STAR, MODE_LINE: do_body = 1'b1;
        default: begin
          s.scan_mode = MODE_NORMAL;
          do_normal   = 1'b1;
        end
      endcase
    end

    // Text outside comments
    if (do_normal) begin
      if (s.escape_pending) begin
        s.escape_pending = 1'b0;
        if (c == CH_NEWLINE) begin
          s.in_double_quote  = 1'b0;
          s.in_single_quote  = 1'b0;
          s.warned_this_line = 1'b0;
        end
      end else if (c == CH_BSLASH) begin
        s.escape_pending = 1'b1;
      end else if (c == CH_DQUOTE) begin
        if (!s.in_single_quote) s.in_double_quote = ~s.in_double_quote;
      end else if (c == CH_SQUOTE) begin
        if (!s.in_double_quote) s.in_single_quote = ~s.in_single_quote;
      end else if (c == CH_SLASH) begin
        if (!s.in_double_quote && !s.in_single_quote) begin
          s.scan_mode = MODE_SLASH;
          body_put    = 1'b0;
        end
      end else if (c == CH_NEWLINE) begin
        s.in_double_quote  = 1'b0;
        s.in_single_quote  = 1'b0;
        s.escape_pending   = 1'b0;
        s.warned_this_line = 1'b0;
      end
      if (body_put) begin
        if (n == 2'd0) r0 = mk_res(c, 1'b1, 1'b0, 1'b0);
        else           r1 = mk_res(c, 1'b1, 1'b0, 1'b0);
        n = n + 2'd1;
      end
    end

    // Comment body characters
    if (do_body) begin
      if (state_i.body_slash_seen &&
          (c == CH_STAR || (c == CH_SLASH && cfg_i.line_comments_enable)) &&
          cfg_i.warn_nested_enable && !state_i.warned_this_line) begin
        warn               = 1'b1;
        s.warned_this_line = 1'b1;
      end
      s.body_slash_seen = (c == CH_SLASH);

      if (state_i.scan_mode == MODE_LINE) begin
        if (c == CH_NEWLINE) begin
          s.scan_mode        = MODE_NORMAL;
          s.body_slash_seen  = 1'b0;
          s.in_double_quote  = 1'b0;
          s.in_single_quote  = 1'b0;
          s.escape_pending   = 1'b0;
          s.warned_this_line = 1'b0;
          r0       = mk_res(c, 1'b1, warn, 1'b0);
          n        = 2'd1;
          body_put = 1'b0;
        end
      end else if (state_i.scan_mode == MODE_BLOCK_STAR && c == CH_SLASH) begin
        s.scan_mode       = MODE_NORMAL;
        s.body_slash_seen = 1'b0;
      end else begin
        s.scan_mode = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
        if (c == CH_NEWLINE) begin
          s.in_double_quote  = 1'b0;
          s.in_single_quote  = 1'b0;
          s.escape_pending   = 1'b0;
          s.warned_this_line = 1'b0;
        end
      end

      if (body_put) begin
        if (keep) begin
          r0 = mk_res(c, 1'b1, warn, 1'b0);
          n  = 2'd1;
        end else if (warn) begin
          r0 = mk_res(8'h00, 1'b0, 1'b1, 1'b0);
          n  = 2'd1;
        end
      end
    end

    // Mark the final result of the transaction
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    state_o   = s;
    res0_o    = r0;
    res1_o    = r1;
    res_cnt_o = n;
  end

endmodule

### src/cmst_outq.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while the output is not stalled.
module cmst_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  cmst_pkg::out_item_t push0_i,
  input  cmst_pkg::out_item_t push1_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cmst_pkg::out_item_t out_data_o
);
  import cmst_pkg::*;

  out_item_t          entry_q [QDEPTH];
  logic [QAW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]     count_q, count_d;
  logic               pop;
  logic [QAW-1:0]     wr_ptr_nx;

  // Room for a transaction that may bring two results
  assign room_o      = count_q <= QCW'(QDEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + QAW'(1);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + QAW'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    count_d  = count_q + QCW'(push_cnt_i) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store results
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) entry_q[wr_ptr_q] <= push0_i;
    if (push_cnt_i == 2'd2) entry_q[wr_ptr_nx] <= push1_i;
  end

endmodule

### src/comment_strip_filter.sv
// Top level of the comment strip filter: input stage, scan state, config port, result queue.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   config    input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One character per cycle while the result queue has room: an accepted transaction
// is held in the input register, then the scan logic updates state and pushes 0, 1
// or 2 results into a four-entry result queue.
// The input stalls while the input register holds a transaction and the queue has
// fewer than two free entries.
// Reset clears scan state, configuration and the queue; no clearing pass.
module comment_strip_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cmst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cmst_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [cmst_pkg::REG_AW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cmst_pkg::*;

  cfg_t        cfg_q;
  scan_state_t state_q, state_d;
  logic        s1_valid_q, s1_valid_d;
  in_item_t    s1_item_q;
  logic        in_accept;
  logic        advance;
  logic        room;
  out_item_t   res0, res1;
  logic [1:0]  res_cnt;
  logic [1:0]  push_cnt;
  logic        cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LINE_EN: cfg_q.line_comments_enable <= pwdata[0];
        REG_KEEP:    cfg_q.keep_comment_text    <= pwdata[0];
        REG_WARN_EN: cfg_q.warn_nested_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_LINE_EN: prdata[0] = cfg_q.line_comments_enable;
      REG_KEEP:    prdata[0] = cfg_q.keep_comment_text;
      REG_WARN_EN: prdata[0] = cfg_q.warn_nested_enable;
      default:     prdata    = '0;
    endcase
  end

  // Input register: hold the transaction until the queue has room
  assign advance    = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_item_q <= in_data_i;
  end

  // Scan logic
  cmst_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .item_i    (s1_item_q),
    .state_o   (state_d),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign push_cnt = advance ? res_cnt : 2'd0;

  // Result queue
  cmst_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/comment_strip_filter_tb.sv
// Testbench for comment_strip_filter: directed and random text checked against a built-in predictor.
module comment_strip_filter_tb;
  import cmst_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int IDLE_LIMIT     = 5000;
  localparam int MAX_REPORTS    = 40;
  localparam int RUN_LIMIT      = 3_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [REG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor configuration and scan state
  cfg_t        filter_cfg;
  scan_mode_e  mode;
  logic        in_dq;
  logic        in_sq;
  logic        esc_pending;
  logic        body_slash;
  logic        warned_line;

  out_item_t   char_results[$];
  out_item_t   expected_chars[$];
  int          mismatches  = 0;
  int          chars_sent  = 0;
  bit          no_idle     = 1'b0;
  bit          rx_hold_req = 1'b0;

  comment_strip_filter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void add_result(logic [7:0] ch, logic vld, logic warn, logic err);
    out_item_t r;
    r.out_char           = vld ? ch : 8'h00;
    r.char_valid         = vld;
    r.nested_warning     = warn;
    r.unterminated_error = err;
    r.last               = 1'b0;
    char_results.push_back(r);
  endfunction

  // Clear quote, escape and warning state at each newline
  function automatic void clear_line_state();
    in_dq       = 1'b0;
    in_sq       = 1'b0;
    esc_pending = 1'b0;
    warned_line = 1'b0;
  endfunction

  function automatic void clear_scan_state();
    mode       = MODE_NORMAL;
    body_slash = 1'b0;
    clear_line_state();
  endfunction

  // One character of ordinary text
  function automatic void scan_text_char(logic [7:0] c);
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (c == CH_NEWLINE) clear_line_state();
      add_result(c, 1'b1, 1'b0, 1'b0);
      return;
    end
    if (c == CH_BSLASH) begin
      esc_pending = 1'b1;
    end else if (c == CH_DQUOTE) begin
      if (!in_sq) in_dq = ~in_dq;
    end else if (c == CH_SQUOTE) begin
      if (!in_dq) in_sq = ~in_sq;
    end else if (c == CH_SLASH) begin
      // hold the slash until the next character decides
      if (!in_dq && !in_sq) begin
        mode = MODE_SLASH;
        return;
      end
    end else if (c == CH_NEWLINE) begin
      clear_line_state();
    end
    add_result(c, 1'b1, 1'b0, 1'b0);
  endfunction

  // One character inside a block or line comment body
  function automatic void scan_comment_char(logic [7:0] c);
    logic warn;
    warn = 1'b0;
    if (body_slash && (c == CH_STAR || (c == CH_SLASH && filter_cfg.line_comments_enable)))
      if (filter_cfg.warn_nested_enable && !warned_line) begin
        warn        = 1'b1;
        warned_line = 1'b1;
      end
    body_slash = (c == CH_SLASH);

    if (mode == MODE_LINE) begin
      // the terminating newline always goes out
      if (c == CH_NEWLINE) begin
        mode       = MODE_NORMAL;
        body_slash = 1'b0;
        clear_line_state();
        add_result(c, 1'b1, warn, 1'b0);
        return;
      end
    end else if (mode == MODE_BLOCK_STAR && c == CH_SLASH) begin
      mode       = MODE_NORMAL;
      body_slash = 1'b0;
      if (filter_cfg.keep_comment_text) add_result(c, 1'b1, warn, 1'b0);
      else if (warn) add_result(8'h00, 1'b0, 1'b1, 1'b0);
      return;
    end else begin
      mode = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
      if (c == CH_NEWLINE) clear_line_state();
    end
    if (filter_cfg.keep_comment_text) add_result(c, 1'b1, warn, 1'b0);
    else if (warn) add_result(8'h00, 1'b0, 1'b1, 1'b0);
  endfunction

  // Work out the results of one accepted transaction and queue them
  function automatic void filter_char(in_item_t item);
    logic [7:0] c;
    logic       keep;
    c    = item.in_byte;
    keep = filter_cfg.keep_comment_text;
    char_results.delete();
    if (item.end_of_text) begin
      if (mode == MODE_SLASH) begin
        add_result(CH_SLASH, 1'b1, 1'b0, 1'b0);
      end else if (mode == MODE_BLOCK || mode == MODE_BLOCK_STAR) begin
        if (keep) begin
          add_result(CH_STAR, 1'b1, 1'b0, 1'b1);
          add_result(CH_SLASH, 1'b1, 1'b0, 1'b0);
        end else begin
          add_result(8'h00, 1'b0, 1'b0, 1'b1);
        end
      end
      if (char_results.size() == 0) add_result(8'h00, 1'b0, 1'b0, 1'b0);
      clear_scan_state();
    end else if (mode == MODE_SLASH) begin
      if (c == CH_STAR || (c == CH_SLASH && filter_cfg.line_comments_enable)) begin
        mode       = (c == CH_STAR) ? MODE_BLOCK : MODE_LINE;
        body_slash = 1'b0;
        if (keep) begin
          add_result(CH_SLASH, 1'b1, 1'b0, 1'b0);
          add_result(c, 1'b1, 1'b0, 1'b0);
        end else begin
          add_result(CH_SPACE, 1'b1, 1'b0, 1'b0);
        end
      end else begin
        mode = MODE_NORMAL;
        add_result(CH_SLASH, 1'b1, 1'b0, 1'b0);
        scan_text_char(c);
      end
    end else if (mode == MODE_BLOCK || mode == MODE_BLOCK_STAR || mode == MODE_LINE) begin
      scan_comment_char(c);
    end else begin
      mode = MODE_NORMAL;
      scan_text_char(c);
    end
    if (char_results.size() > 0) char_results[char_results.size()-1].last = 1'b1;
    foreach (char_results[i]) expected_chars.push_back(char_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_v, act_v);
    end
  endtask

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got %h", $time, out_data);
      end else begin
        want = expected_chars.pop_front();
        check_field("out_char", want.out_char, out_data.out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(out_data.char_valid));
        check_field("nested_warning", 8'(want.nested_warning),
                    8'(out_data.nested_warning));
        check_field("unterminated_error", 8'(want.unterminated_error),
                    8'(out_data.unterminated_error));
        check_field("last", 8'(want.last), 8'(out_data.last));
      end
    end
  end

  // Stall the result channel at random; hold off for a long stretch on request
  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      wait_cycles = no_idle ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one transaction after a random gap and predict it once accepted
  task automatic send_char(input logic [7:0] ch, input logic eot);
    in_item_t item;
    int       gap;
    item.in_byte     = ch;
    item.end_of_text = eot;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    filter_char(item);
    chars_sent++;
  endtask

  task automatic send_eot();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Write one register through the APB port, then leave the bus idle
  task automatic write_reg(input logic [1:0] idx, input logic val);
    logic [31:0] wdata;
    wdata    = $urandom();
    wdata[0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LINE_EN: filter_cfg.line_comments_enable = val;
      REG_KEEP:    filter_cfg.keep_comment_text    = val;
      REG_WARN_EN: filter_cfg.warn_nested_enable   = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter_mode(input logic line_en, input logic keep, input logic warn_en);
    write_reg(REG_LINE_EN, line_en);
    write_reg(REG_KEEP, keep);
    write_reg(REG_WARN_EN, warn_en);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline drain
  task automatic wait_idle();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    while (expected_chars.size() != 0 && cycles < IDLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (expected_chars.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_chars.size());
      expected_chars.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Character with heavy weight on the ones the scanner cares about
  function automatic logic [7:0] mix_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1:    c = CH_SLASH;
      2:       c = CH_STAR;
      3:       c = CH_DQUOTE;
      4:       c = CH_SQUOTE;
      5:       c = CH_BSLASH;
      6:       c = CH_NEWLINE;
      7:       c = CH_SPACE;
      8:       c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    return c;
  endfunction

  // One piece of C-like text: mostly well-formed, some noise
  task automatic send_fragment();
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      1: begin
        send_text("/*");
        repeat ($urandom_range(0, 6)) send_char(mix_char(), 1'b0);
        // leave some block comments open
        if ($urandom_range(0, 7) != 0) send_text("*/");
      end
      2: begin
        send_text("//");
        repeat ($urandom_range(0, 5)) send_char(mix_char(), 1'b0);
        send_char(CH_NEWLINE, 1'b0);
      end
      3: begin
        send_char(CH_DQUOTE, 1'b0);
        repeat ($urandom_range(0, 4)) send_char(mix_char(), 1'b0);
        send_char(CH_DQUOTE, 1'b0);
      end
      4: begin
        send_char(CH_SQUOTE, 1'b0);
        send_char(mix_char(), 1'b0);
        send_char(CH_SQUOTE, 1'b0);
      end
      5: begin
        send_char(CH_BSLASH, 1'b0);
        send_char(mix_char(), 1'b0);
      end
      6: send_char(CH_NEWLINE, 1'b0);
      7: repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
      8: repeat ($urandom_range(1, 3)) send_char(mix_char(), 1'b0);
      default: begin
        if ($urandom_range(0, 3) == 0) send_eot();
        else send_char(CH_SPACE, 1'b0);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: byte extremes, held slash, escapes, strip, end of text
  task automatic test_strip_basics();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("/x\\//**//");
    send_eot();
    send_text("/*a");
    send_eot();
  endtask

  // All options on: quotes, line comment, nested openers, open comment at end
  task automatic test_keep_and_nesting();
    wait_idle();
    set_filter_mode(1'b1, 1'b1, 1'b1);
    send_text("\"'//\"///*\n/*/*");
    send_eot();
  endtask

  // Random text under every combination of the three options
  task automatic test_random_text();
    int target;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      set_filter_mode(phase[0], phase[1], phase[2]);
      target = chars_sent + 140;
      while (chars_sent < target) begin
        no_idle = ($urandom_range(0, 7) == 0);
        send_fragment();
      end
      no_idle = 1'b0;
      send_eot();
    end
  endtask

  // Hold off the result side while text keeps coming, so the input stalls
  task automatic test_backpressure();
    int target;
    wait_idle();
    set_filter_mode(1'b1, 1'b0, 1'b1);
    no_idle     = 1'b1;
    rx_hold_req = 1'b1;
    target = chars_sent + 80;
    while (chars_sent < target) send_fragment();
    no_idle = 1'b0;
    send_eot();
  endtask

  initial begin : stimulus
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_n    <= 1'b0;
    filter_cfg = '0;
    clear_scan_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_strip_basics();
    test_keep_and_nesting();
    test_random_text();
    test_backpressure();
    wait_idle();

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("%0t: run limit reached", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
